/* rtl/lcat_pkg.sv */
// ----------------------------------------------------------------------------
// lcat_pkg
// shared types and constants of the layer cache admission table
// ----------------------------------------------------------------------------
package lcat_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int THR_W         = 16;
	localparam int ID_W          = 32;

	typedef enum logic [1:0] {
		CMD_VISIT = 2'd0,
		CMD_BEGIN = 2'd1,
		CMD_END   = 2'd2,
		CMD_PURGE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CLS_PICTURE = 2'd0,
		CLS_FILTER  = 2'd1,
		CLS_OPACITY = 2'd2,
		CLS_NONE    = 2'd3
	} cls_t;

	typedef enum logic [2:0] {
		ST_NOT_CACHABLE = 3'd0,
		ST_RECORDING    = 3'd1,
		ST_HAS_CACHED   = 3'd2,
		ST_JUST_CACHED  = 3'd3,
		ST_RENDER_ERROR = 3'd4,
		ST_FRAME_DONE   = 3'd5
	} cstate_t;

	typedef enum logic [1:0] {
		REG_PICTURE = 2'd0,
		REG_FILTER  = 2'd1,
		REG_OPACITY = 2'd2
	} reg_idx_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_SCAN = 1'b1
	} fsm_t;

	typedef struct packed {
		logic [ID_W-1:0]  layer;
		logic [ID_W-1:0]  generation;
		logic [THR_W-1:0] count;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/lcat_ram.sv */
// ----------------------------------------------------------------------------
// lcat_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lcat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/layer_cache_admission_table_top.sv */
// ----------------------------------------------------------------------------
// layer_cache_admission_table_top
// tracks layers by id and decides when a layer is stable enough to cache
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// ---------+--------------------+---------------------------------------------
// command  | start, busy        | command, layer_key, generation, layer_class,
//          |                    | nested_render, snapshot_ok, clear_records
// result   | done (one cycle)   | admit_state, draw_from_cache, table_full
// config   | cfg_we             | cfg_index, cfg_data
//
// frame commands, nested visits and non cachable classes: result in the cycle
// after the transfer. a table visit scans the entry ram one entry per cycle
// until an entry hits or the last entry has been checked.
// valid, evicted and snapshot flags sit in flip-flops and are cleared by reset.
// the receiver cannot stall; a new command is taken while the result shows.
// ----------------------------------------------------------------------------
module layer_cache_admission_table_top
	import lcat_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        command,
	input  logic [ID_W-1:0]   layer_key,
	input  logic [ID_W-1:0]   generation,
	input  logic [1:0]        layer_class,
	input  logic              nested_render,
	input  logic              snapshot_ok,
	input  logic              clear_records,
	output logic              done,
	output logic [2:0]        admit_state,
	output logic              draw_from_cache,
	output logic              table_full,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [THR_W-1:0]  cfg_data
);

	fsm_t state_q, state_d;

	logic [THR_W-1:0] pic_thr_q, fil_thr_q, opa_thr_q;

	logic [TABLE_ENTRIES-1:0] valid_q, evict_q, snap_q;

	logic [ID_W-1:0]  id_q, gen_q;
	logic [THR_W-1:0] limit_q;
	logic             snap_ok_q;

	logic [IDX_W-1:0] ptr_q, chk_q, free_idx_q;
	logic             chk_v_q, free_found_q;

	logic             done_q, full_q;
	cstate_t          cstate_q;

	logic             accept;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata, ram_rdata;
	logic [ENTRY_W-1:0] ram_rbits;

	logic             hit, last, free_now, free_any;
	logic [IDX_W-1:0] free_sel;
	logic [THR_W-1:0] cnt_inc;

	logic             res_v, res_full;
	cstate_t          res_state;
	logic             set_valid, clr_evict, set_snap, clr_snap;
	logic [IDX_W-1:0] upd_idx;

	assign accept    = start && (state_q == FSM_IDLE);
	assign busy      = (state_q != FSM_IDLE);
	assign ram_rdata = entry_t'(ram_rbits);

	lcat_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ptr_q),
		.rdata(ram_rbits)
	);

	// lookup of the entry whose data is on the ram output
	assign hit      = chk_v_q && valid_q[chk_q] && (ram_rdata.layer == id_q);
	assign last     = chk_v_q && (chk_q == IDX_W'(TABLE_ENTRIES - 1));
	assign free_now = chk_v_q && !valid_q[chk_q];
	assign free_any = free_found_q || free_now;
	assign free_sel = free_found_q ? free_idx_q : chk_q;
	assign cnt_inc  = (ram_rdata.count == {THR_W{1'b1}}) ? ram_rdata.count
		: ram_rdata.count + THR_W'(1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (accept && cmd_t'(command) == CMD_VISIT && !nested_render
						&& cls_t'(layer_class) != CLS_NONE) begin
					state_d = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				if (hit || last) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		res_v     = 1'b0;
		res_state = ST_NOT_CACHABLE;
		res_full  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = chk_q;
		ram_wdata = ram_rdata;
		set_valid = 1'b0;
		clr_evict = 1'b0;
		set_snap  = 1'b0;
		clr_snap  = 1'b0;
		upd_idx   = chk_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					if (cmd_t'(command) != CMD_VISIT) begin
						res_v     = 1'b1;
						res_state = ST_FRAME_DONE;
					end else if (nested_render || cls_t'(layer_class) == CLS_NONE) begin
						res_v = 1'b1;
					end
				end
			end
			FSM_SCAN: begin
				if (hit) begin
					res_v     = 1'b1;
					ram_we    = 1'b1;
					clr_evict = 1'b1;
					if (ram_rdata.generation != gen_q) begin
						ram_wdata.generation = gen_q;
						ram_wdata.count      = '0;
						clr_snap             = 1'b1;
						res_state            = ST_RECORDING;
					end else begin
						ram_wdata.count = cnt_inc;
						priority if (cnt_inc < limit_q) begin
							res_state = ST_RECORDING;
						end else if (snap_q[chk_q]) begin
							res_state = ST_HAS_CACHED;
						end else if (!snap_ok_q) begin
							res_state = ST_RENDER_ERROR;
						end else begin
							res_state = ST_JUST_CACHED;
							set_snap  = 1'b1;
						end
					end
				end else if (last) begin
					res_v = 1'b1;
					if (free_any) begin
						ram_we    = 1'b1;
						ram_waddr = free_sel;
						ram_wdata = '{layer: id_q, generation: gen_q, count: THR_W'(1)};
						upd_idx   = free_sel;
						set_valid = 1'b1;
						clr_evict = 1'b1;
						clr_snap  = 1'b1;
						res_state = ST_RECORDING;
					end else begin
						res_full = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= FSM_IDLE;
			pic_thr_q    <= THR_W'(3);
			fil_thr_q    <= THR_W'(3);
			opa_thr_q    <= THR_W'(3);
			valid_q      <= '0;
			evict_q      <= '0;
			snap_q       <= '0;
			ptr_q        <= '0;
			chk_q        <= '0;
			chk_v_q      <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			done_q       <= 1'b0;
			cstate_q     <= ST_NOT_CACHABLE;
			full_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_v;
			if (res_v) begin
				cstate_q <= res_state;
				full_q   <= res_full;
			end

			if (cfg_we) begin
				unique case (cfg_index)
					REG_PICTURE: pic_thr_q <= cfg_data;
					REG_FILTER:  fil_thr_q <= cfg_data;
					REG_OPACITY: opa_thr_q <= cfg_data;
					default: ;
				endcase
			end

			if (accept) begin
				ptr_q        <= '0;
				chk_v_q      <= 1'b0;
				free_found_q <= 1'b0;
				unique case (cmd_t'(command))
					CMD_BEGIN: evict_q <= evict_q | valid_q;
					CMD_END: begin
						valid_q <= valid_q & ~evict_q;
						evict_q <= '0;
						snap_q  <= snap_q & ~(valid_q & evict_q);
					end
					CMD_PURGE: begin
						snap_q <= '0;
						if (clear_records) begin
							valid_q <= '0;
							evict_q <= '0;
						end
					end
					default: ;
				endcase
			end else if (state_q == FSM_SCAN) begin
				ptr_q   <= ptr_q + IDX_W'(1);
				chk_q   <= ptr_q;
				chk_v_q <= 1'b1;
				if (free_now && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= chk_q;
				end
				if (set_valid) valid_q[upd_idx] <= 1'b1;
				if (clr_evict) evict_q[upd_idx] <= 1'b0;
				if (clr_snap)  snap_q[upd_idx]  <= 1'b0;
				if (set_snap)  snap_q[upd_idx]  <= 1'b1;
			end
		end
	end

	// visit operands, held for the scan
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q      <= layer_key;
			gen_q     <= generation;
			snap_ok_q <= snapshot_ok;
			unique case (cls_t'(layer_class))
				CLS_PICTURE: limit_q <= pic_thr_q;
				CLS_FILTER:  limit_q <= fil_thr_q;
				default:     limit_q <= opa_thr_q;
			endcase
		end
	end

	assign done            = done_q;
	assign admit_state     = cstate_q;
	assign draw_from_cache = (cstate_q == ST_HAS_CACHED) || (cstate_q == ST_JUST_CACHED);
	assign table_full      = full_q;

`ifndef NO_ASSERTIONS
	a_full_not_cachable: assert property (@(posedge clk) disable iff (!arst_n)
		done && table_full |-> admit_state == ST_NOT_CACHABLE)
		else $error("table full with a cachable state");

	a_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == FSM_SCAN)
		else $error("entry write outside of a scan");

	a_hit_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_SCAN && hit |=> done && state_q == FSM_IDLE)
		else $error("hit did not finish the visit");

	a_evict_subset: assert property (@(posedge clk) disable iff (!arst_n)
		(evict_q & ~valid_q) == '0)
		else $error("evicted mark on a free entry");
`endif

endmodule
